FILE: hdl/skf_pkg.sv
// Shared constants, types and codes for the scalar Kalman filter.
// No dependencies; used by scalar_kalman_filter_top, skf_check_pkg and tb_top.
package skf_pkg;

    localparam int DATA_W = 32;
    localparam int FRAC_W = 16;
    localparam int GAIN_W = FRAC_W + 1;
    localparam int STEPS  = GAIN_W;
    localparam int CNT_W  = $clog2(STEPS + 1);

    localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1) << FRAC_W;

    localparam logic [DATA_W-1:0] PN_RESET  = DATA_W'(66);
    localparam logic [DATA_W-1:0] MN_RESET  = DATA_W'(1) << FRAC_W;
    localparam logic [DATA_W-1:0] VAR_RESET = DATA_W'(1) << FRAC_W;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_PREP = 6'b000010,
        ST_SUM  = 6'b000100,
        ST_DIV  = 6'b001000,
        ST_MUL  = 6'b010000,
        ST_FIN  = 6'b100000
    } state_t;

    typedef enum logic [1:0] {
        REG_PROCESS_NOISE     = 2'd0,
        REG_MEASUREMENT_NOISE = 2'd1,
        REG_INITIAL_ESTIMATE  = 2'd2,
        REG_INITIAL_VARIANCE  = 2'd3
    } cfg_index_t;

endpackage

FILE: hdl/scalar_kalman_filter_top.sv
// Scalar Kalman filter, Q16.16 fixed point, bit-serial divider and multipliers.
// Depends on skf_pkg.
//
// Usage:
//   Input channel (in_valid/in_ready/sample) carries one signed Q16.16 request.
//   Output channel (out_valid/out_ready/estimate/variance/gain) carries one
//   result per request: new estimate, new variance and the Q1.16 gain used.
//   Configuration (cfg_wr_en, cfg_index, cfg_wdata) is written only while the
//   block is idle; writing initial_estimate or initial_variance reloads state.
//
// Sequence: a request passes through PREP (grow the variance, form the
//   innovation), SUM (form the divisor), DIV (the restoring divider) and MUL (the
//   two shift-add multipliers, one gain bit per cycle each, so the gain width sets
//   both step counts), then FIN, which saturates into the output register. Result
//   valid and in_ready both return when FIN completes, so a new request is
//   accepted only once the previous one has finished.
//
// Reset: estimate 0, variance one, noise registers to their defaults. A stalled
//   receiver holds the result in the output register; the next request runs up
//   to its final step and waits there until the output register frees.
module scalar_kalman_filter_top (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic signed [skf_pkg::DATA_W-1:0]  sample,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [skf_pkg::DATA_W-1:0]  estimate,
    output logic        [skf_pkg::DATA_W-1:0]  variance,
    output logic        [skf_pkg::GAIN_W-1:0]  gain,
    input  logic                               cfg_wr_en,
    input  logic        [1:0]                  cfg_index,
    input  logic        [skf_pkg::DATA_W-1:0]  cfg_wdata
);

    localparam int DW = skf_pkg::DATA_W;
    localparam int GW = skf_pkg::GAIN_W;
    localparam int CW = skf_pkg::CNT_W;

    // control and state
    skf_pkg::state_t        state_reg, state_next;
    logic [CW-1:0]          cnt_reg, cnt_next;
    logic                   out_valid_reg, out_valid_next;
    logic [DW-1:0]          pn_reg, pn_next;
    logic [DW-1:0]          mn_reg, mn_next;
    logic signed [DW-1:0]   est_reg, est_next;
    logic [DW-1:0]          var_reg, var_next;

    // datapath
    logic signed [DW-1:0]   z_reg;
    logic [DW-1:0]          p_reg;
    logic [DW:0]            s_reg;
    logic signed [DW:0]     diff_reg;
    logic [DW+1:0]          rem_reg;
    logic [GW-1:0]          q_reg;
    logic [GW-1:0]          k_sr_reg;
    logic [GW-1:0]          omk_sr_reg;
    logic [GW-1:0]          gain_reg;
    logic signed [DW+1:0]   macc_reg;
    logic                   mbit_reg;
    logic [DW:0]            vacc_reg;
    logic                   vbit_reg;
    logic signed [DW-1:0]   out_est_reg;
    logic [DW-1:0]          out_var_reg;
    logic [GW-1:0]          out_gain_reg;

    logic                   last_step;
    logic                   out_free;
    logic                   fin_fire;

    // variance grown by process noise, saturating
    logic [DW:0]            psum;
    logic [DW-1:0]          p_sat;

    // restoring divider step
    logic [DW+1:0]          cand;
    logic                   ge;
    logic [GW-1:0]          q_step;
    logic [GW-1:0]          k_val;

    // multiplier steps
    logic signed [DW+1:0]   msum;
    logic [DW:0]            vsum;

    // final estimate
    logic signed [DW+2:0]   delta;
    logic signed [DW+3:0]   est_wide;
    logic signed [DW-1:0]   est_sat;
    logic [DW-1:0]          var_new;

    assign in_ready  = (state_reg == skf_pkg::ST_IDLE);
    assign out_valid = out_valid_reg;
    assign estimate  = out_est_reg;
    assign variance  = out_var_reg;
    assign gain      = out_gain_reg;

    assign last_step = (cnt_reg == CW'(skf_pkg::STEPS - 1));
    assign out_free  = !out_valid_reg || out_ready;
    assign fin_fire  = (state_reg == skf_pkg::ST_FIN) && out_free;

    assign psum  = {1'b0, var_reg} + {1'b0, pn_reg};
    assign p_sat = psum[DW] ? {DW{1'b1}} : psum[DW-1:0];

    // first step compares without shifting, later steps shift left first
    assign cand   = (cnt_reg == '0) ? rem_reg : {rem_reg[DW:0], 1'b0};
    assign ge     = (cand >= {1'b0, s_reg});
    assign q_step = {q_reg[GW-2:0], ge};
    assign k_val  = (s_reg == '0) ? '0 : q_step;

    // signed shift-add: add the innovation when the gain bit is set, halve
    assign msum = macc_reg + (k_sr_reg[0] ? {diff_reg[DW], diff_reg} : '0);
    assign vsum = vacc_reg + (omk_sr_reg[0] ? {1'b0, p_reg} : '0);

    // product >> FRAC bits = accumulator * 2 + last bit shifted out
    assign delta    = {macc_reg, mbit_reg};
    assign est_wide = {{4{est_reg[DW-1]}}, est_reg} + {delta[DW+2], delta};
    assign var_new  = {vacc_reg[DW-2:0], vbit_reg};

    always_comb
    begin
        if (est_wide[DW+3:DW-1] == '0 || est_wide[DW+3:DW-1] == '1)
        begin
            est_sat = est_wide[DW-1:0];
        end
        else if (est_wide[DW+3])
        begin
            est_sat = {1'b1, {(DW-1){1'b0}}};
        end
        else
        begin
            est_sat = {1'b0, {(DW-1){1'b1}}};
        end
    end

    // sequencer and configuration
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        pn_next        = pn_reg;
        mn_next        = mn_reg;
        est_next       = est_reg;
        var_next       = var_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            skf_pkg::ST_IDLE:
            begin
                if (cfg_wr_en)
                begin
                    unique case (skf_pkg::cfg_index_t'(cfg_index))
                        skf_pkg::REG_PROCESS_NOISE:     pn_next  = cfg_wdata;
                        skf_pkg::REG_MEASUREMENT_NOISE: mn_next  = cfg_wdata;
                        skf_pkg::REG_INITIAL_ESTIMATE:  est_next = cfg_wdata;
                        skf_pkg::REG_INITIAL_VARIANCE:  var_next = cfg_wdata;
                        default:                        pn_next  = pn_reg;
                    endcase
                end
                if (in_valid)
                begin
                    state_next = skf_pkg::ST_PREP;
                end
            end
            skf_pkg::ST_PREP:
            begin
                state_next = skf_pkg::ST_SUM;
            end
            skf_pkg::ST_SUM:
            begin
                cnt_next   = '0;
                state_next = skf_pkg::ST_DIV;
            end
            skf_pkg::ST_DIV:
            begin
                cnt_next = cnt_reg + CW'(1);
                if (last_step)
                begin
                    cnt_next   = '0;
                    state_next = skf_pkg::ST_MUL;
                end
            end
            skf_pkg::ST_MUL:
            begin
                cnt_next = cnt_reg + CW'(1);
                if (last_step)
                begin
                    cnt_next   = '0;
                    state_next = skf_pkg::ST_FIN;
                end
            end
            skf_pkg::ST_FIN:
            begin
                if (out_free)
                begin
                    est_next       = est_sat;
                    var_next       = var_new;
                    out_valid_next = 1'b1;
                    state_next     = skf_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = skf_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= skf_pkg::ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            pn_reg        <= skf_pkg::PN_RESET;
            mn_reg        <= skf_pkg::MN_RESET;
            est_reg       <= '0;
            var_reg       <= skf_pkg::VAR_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            pn_reg        <= pn_next;
            mn_reg        <= mn_next;
            est_reg       <= est_next;
            var_reg       <= var_next;
        end
    end

    // datapath registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            z_reg <= sample;
        end

        if (state_reg == skf_pkg::ST_PREP)
        begin
            p_reg    <= p_sat;
            diff_reg <= {z_reg[DW-1], z_reg} - {est_reg[DW-1], est_reg};
        end

        if (state_reg == skf_pkg::ST_SUM)
        begin
            s_reg   <= {1'b0, p_reg} + {1'b0, mn_reg};
            rem_reg <= {2'b00, p_reg};
            q_reg   <= '0;
        end

        if (state_reg == skf_pkg::ST_DIV)
        begin
            rem_reg <= ge ? (cand - {1'b0, s_reg}) : cand;
            q_reg   <= q_step;
            if (last_step)
            begin
                // load the gain and its complement into the multiplier shifters
                k_sr_reg   <= k_val;
                omk_sr_reg <= skf_pkg::GAIN_ONE - k_val;
                gain_reg   <= k_val;
                macc_reg   <= '0;
                mbit_reg   <= 1'b0;
                vacc_reg   <= '0;
                vbit_reg   <= 1'b0;
            end
        end

        if (state_reg == skf_pkg::ST_MUL)
        begin
            macc_reg   <= {msum[DW+1], msum[DW+1:1]};
            mbit_reg   <= msum[0];
            vacc_reg   <= {1'b0, vsum[DW:1]};
            vbit_reg   <= vsum[0];
            k_sr_reg   <= {1'b0, k_sr_reg[GW-1:1]};
            omk_sr_reg <= {1'b0, omk_sr_reg[GW-1:1]};
        end

        if (fin_fire)
        begin
            out_est_reg  <= est_sat;
            out_var_reg  <= var_new;
            out_gain_reg <= gain_reg;
        end
    end

endmodule

FILE: tb/skf_check_pkg.sv
// Prediction and checking for the scalar Kalman filter testbench.
// Depends on skf_pkg; used by tb_top.
package skf_check_pkg;

    import skf_pkg::*;

    localparam longint EST_MIN = -(longint'(1) << (DATA_W - 1));
    localparam longint EST_MAX = (longint'(1) << (DATA_W - 1)) - 1;

    typedef struct packed {
        logic [DATA_W-1:0] estimate;
        logic [DATA_W-1:0] variance;
        logic [GAIN_W-1:0] gain;
    } filter_update_t;

    class kalman_tracker;
        logic [DATA_W-1:0] process_noise;
        logic [DATA_W-1:0] measurement_noise;
        logic [DATA_W-1:0] est_state;
        logic [DATA_W-1:0] var_state;
        filter_update_t    updates_due[$];
        int unsigned       failures;

        function new();
            process_noise     = PN_RESET;
            measurement_noise = MN_RESET;
            est_state         = '0;
            var_state         = VAR_RESET;
            failures          = 0;
        endfunction

        function void write_reg(cfg_index_t idx, logic [DATA_W-1:0] value);
            case (idx)
                REG_PROCESS_NOISE:     process_noise = value;
                REG_MEASUREMENT_NOISE: measurement_noise = value;
                REG_INITIAL_ESTIMATE:  est_state = value;
                REG_INITIAL_VARIANCE:  var_state = value;
                default: ;
            endcase
        endfunction

        // One filter step: grow, divide for the gain, then pull estimate and shrink variance.
        function filter_update_t advance(logic [DATA_W-1:0] z);
            logic [DATA_W:0]   grown;
            logic [DATA_W-1:0] prior;
            logic [DATA_W:0]   denom;
            longint unsigned   rem;
            logic [GAIN_W-1:0] k;
            longint            diff;
            longint            pulled;
            longint unsigned   shrunk;
            filter_update_t    upd;

            grown = {1'b0, var_state} + {1'b0, process_noise};
            prior = grown[DATA_W] ? '1 : grown[DATA_W-1:0];
            denom = {1'b0, prior} + {1'b0, measurement_noise};

            // restoring division, quotient truncated; zero divisor leaves gain at zero
            k = '0;
            if (denom != 0)
            begin
                rem = {32'b0, prior};
                if (rem >= denom)
                begin
                    rem -= denom;
                    k = GAIN_W'(1);
                end
                for (int i = 0; i < FRAC_W; i++)
                begin
                    rem = rem << 1;
                    k   = k << 1;
                    if (rem >= denom)
                    begin
                        rem -= denom;
                        k[0] = 1'b1;
                    end
                end
            end
            if (k > GAIN_ONE)
                k = GAIN_ONE;

            diff   = longint'($signed(z)) - longint'($signed(est_state));
            pulled = longint'($signed(est_state)) + ((diff * longint'(k)) >>> FRAC_W);
            if (pulled < EST_MIN)
                pulled = EST_MIN;
            if (pulled > EST_MAX)
                pulled = EST_MAX;
            est_state = pulled[DATA_W-1:0];

            shrunk    = (longint'(prior) * longint'(GAIN_ONE - k)) >> FRAC_W;
            var_state = shrunk[DATA_W-1:0];

            upd.estimate = est_state;
            upd.variance = var_state;
            upd.gain     = k;
            return upd;
        endfunction

        function void note_sample(logic [DATA_W-1:0] z);
            updates_due.push_back(advance(z));
        endfunction

        task report(string msg);
            $display("MISMATCH at %0t: %s", $time, msg);
            failures++;
        endtask

        task check_update(logic [DATA_W-1:0] est, logic [DATA_W-1:0] var_out,
                          logic [GAIN_W-1:0] k);
            filter_update_t due;
            if (updates_due.size() == 0)
            begin
                report("result arrived with no request outstanding");
                return;
            end
            due = updates_due.pop_front();
            if (est !== due.estimate)
                report($sformatf("estimate %0d, predicted %0d",
                                 $signed(est), $signed(due.estimate)));
            if (var_out !== due.variance)
                report($sformatf("variance %0d, predicted %0d", var_out, due.variance));
            if (k !== due.gain)
                report($sformatf("gain %0d, predicted %0d", k, due.gain));
        endtask
    endclass

endpackage

FILE: tb/tb_top.sv
// Top-level testbench for scalar_kalman_filter_top: directed and random samples,
// randomized handshake pressure and configuration. Depends on skf_pkg, skf_check_pkg.
module tb_top;

    import skf_pkg::*;
    import skf_check_pkg::*;

    logic                     clk;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_ready;
    logic signed [DATA_W-1:0] sample;
    logic                     out_valid;
    logic                     out_ready;
    logic signed [DATA_W-1:0] estimate;
    logic        [DATA_W-1:0] variance;
    logic        [GAIN_W-1:0] gain;
    logic                     cfg_wr_en;
    logic        [1:0]        cfg_index;
    logic        [DATA_W-1:0] cfg_wdata;

    kalman_tracker tracker;

    // Handshake pressure knobs, percent of cycles spent idle or stalled.
    int unsigned sender_idle_pct;
    int unsigned receiver_stall_pct;
    // Nonzero asks the receiver to hold out_ready low for that many cycles.
    int unsigned hold_request;

    scalar_kalman_filter_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .sample    (sample),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .estimate  (estimate),
        .variance  (variance),
        .gain      (gain),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Watchdog: the slowest legal run is far below this.
    initial
    begin
        #4000000;
        $display("Test completed with failures");
        $finish;
    end

    // Receiver: check each accepted result, then pick out_ready for the next edge.
    // Values read here are the ones settled before the edge.
    initial
    begin : receiver
        int unsigned hold_left;
        hold_left = 0;
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
                tracker.check_update(estimate, variance, gain);
            if (hold_request != 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left != 0)
            begin
                // hold off for the whole stretch so the block backs up
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= receiver_stall_pct);
            end
        end
    end

    // Offer one request, idling first at random; return at the accepting edge.
    // The caller must assign in_valid again in this same step.
    task automatic send_sample(input logic [DATA_W-1:0] value);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        sample   <= value;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        tracker.note_sample(value);
    endtask

    // Drop valid and wait until every predicted result has come back.
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (tracker.updates_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Write one register; the enable stays high so writes can run back to back.
    task automatic write_reg(input cfg_index_t idx, input logic [DATA_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        tracker.write_reg(idx, value);
    endtask

    // Set both noise registers; reload the filter state only when asked.
    task automatic load_settings(input logic [DATA_W-1:0] pn, input logic [DATA_W-1:0] mn,
                                 input logic [DATA_W-1:0] est, input logic [DATA_W-1:0] vr,
                                 input bit reload);
        write_reg(REG_PROCESS_NOISE, pn);
        write_reg(REG_MEASUREMENT_NOISE, mn);
        if (reload)
        begin
            write_reg(REG_INITIAL_ESTIMATE, est);
            write_reg(REG_INITIAL_VARIANCE, vr);
        end
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    // Noise and variance values lean toward the extremes and toward small numbers.
    function automatic logic [DATA_W-1:0] draw_noise();
        case ($urandom_range(5))
            0:       return '0;
            1:       return '1;
            2:       return $urandom_range(255);
            3:       return $urandom_range(32'h0010_0000, 32'h0000_1000);
            default: return $urandom;
        endcase
    endfunction

    // Mostly samples near the current estimate, some full-range, a few at the rails.
    function automatic logic [DATA_W-1:0] draw_sample();
        logic [DATA_W-1:0] offset;
        offset = $urandom_range(32'h000F_FFFF) - 32'h0008_0000;
        case ($urandom_range(9))
            0:       return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            1, 2, 3: return $urandom;
            default: return tracker.est_state + offset;
        endcase
    endfunction

    // Pause until drained, pick fresh settings, then stream a batch of requests.
    task automatic run_random_block(input int unsigned count);
        wait_drained();
        load_settings(draw_noise(), draw_noise(), $urandom, draw_noise(),
                      bit'($urandom_range(1)));
        repeat (count) send_sample(draw_sample());
    endtask

    initial
    begin
        rst_n              = 1'b0;
        in_valid           = 1'b0;
        sample             = '0;
        cfg_wr_en          = 1'b0;
        cfg_index          = '0;
        cfg_wdata          = '0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        hold_request       = 0;
        tracker            = new();

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: rails, zero, and a small negative step that must floor.
        send_sample(32'h0000_0000);
        send_sample(32'h7FFF_FFFF);
        send_sample(32'h8000_0000);
        send_sample(32'hFFFF_FFFF);
        send_sample(32'h0000_0001);
        send_sample(32'h0001_8000);

        // Variance overflow: full-scale variance plus full-scale process noise saturates.
        wait_drained();
        load_settings('1, '1, 32'h7FFF_FFFF, '1, 1'b1);
        send_sample(32'h8000_0000);
        send_sample(32'h7FFF_FFFF);

        // Zero denominator: all noise and variance zero, so gain stays zero.
        wait_drained();
        load_settings('0, '0, 32'h8000_0000, '0, 1'b1);
        send_sample(32'h7FFF_FFFF);
        send_sample(32'h0000_0000);

        // Unit gain: no measurement noise, estimate jumps rail to rail.
        wait_drained();
        load_settings(32'd1, '0, '0, '0, 1'b1);
        send_sample(32'h8000_0000);
        send_sample(32'h7FFF_FFFF);
        send_sample(32'h8000_0000);

        // Tiny prior under huge measurement noise: the gain truncates to zero, estimate holds.
        wait_drained();
        load_settings('0, '1, 32'hFFFF_0000, 32'd1, 1'b1);
        send_sample(32'h7FFF_FFFF);
        send_sample(32'h8000_0000);

        // Random phases: free flow, idle sender, stalling receiver, then both.
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 0;
                end
                1:
                begin
                    sender_idle_pct    = 86;
                    receiver_stall_pct = 0;
                end
                2:
                begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 86;
                end
                default:
                begin
                    sender_idle_pct    = 35;
                    receiver_stall_pct = 35;
                end
            endcase
            if (phase == 0)
            begin
                // Back-pressure: block the output for a long stretch while requests
                // keep coming, so the block fills and drops in_ready.
                hold_request = 400;
                repeat (12) send_sample(draw_sample());
            end
            repeat (3) run_random_block(49);
        end

        wait_drained();
        repeat (40) @(posedge clk);

        if (tracker.failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

FILE: scalar_kalman_filter_top.f
hdl/skf_pkg.sv
hdl/scalar_kalman_filter_top.sv
tb/skf_check_pkg.sv
tb/tb_top.sv
